// File: sv/gtr_pkg.sv
// Shared types and fixed-point constants of the Gouraud triangle rasteriser.
package gtr_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int COLOR_BITS = 8;
	localparam int XW         = COORD_BITS + FRAC_BITS;   // edge X, 12.16
	localparam int CW         = COLOR_BITS + FRAC_BITS;   // edge colour, 8.16
	localparam int NUM_W      = CW + FRAC_BITS;           // divider dividend
	localparam int ACC_W      = 32;                       // span colour accumulator

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [1:0] COMP_X    = 2'd0;
	localparam logic [1:0] COMP_LAST = 2'd3;
	localparam logic [1:0] EDGE_LAST = 2'd2;
	localparam logic [1:0] SPAN_LAST = 2'd2;

	typedef enum logic [1:0] {
		PH_DONE,
		PH_UPPER,
		PH_LOWER
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE,
		ST_EDGE_WAIT,
		ST_INIT,
		ST_SEEK_A,
		ST_SEEK_B,
		ST_SPAN,
		ST_SPAN_WAIT,
		ST_SPAN_INIT,
		ST_STEP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       load_vtx;
		logic       pix_capture;
		logic       pix_clear;
		logic       div_start;
		logic       span_mode;
		logic       edge_wr;
		logic       init_walk;
		logic       seek_a;
		logic       walk;
		logic       span_wr;
		logic       span_init;
		logic       out_load;
		logic [1:0] edge_sel;
		logic [1:0] comp_sel;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic dy_pos;
		logic phase_done;
		logic span_nonempty;
		logic row_end;
		logic out_free;
	} sts_t;

endpackage

// File: sv/gtr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module gtr_div import gtr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [XW-1:0]    den,
	output logic [NUM_W-1:0] quo,
	output logic             busy,
	output logic             done
);

	localparam logic [5:0] LAST = 6'(NUM_W - 1);

	logic [NUM_W-1:0] quo_q;
	logic [XW-1:0]    rem_q;
	logic [XW-1:0]    den_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [XW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? XW'(trial - {1'b0, den_q}) : trial[XW-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// File: sv/gtr_datapath.sv
// Vertex store, edge walkers, span cursor and result registers of the rasteriser.
module gtr_datapath import gtr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [1:0]            vertex_slot,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic [COLOR_BITS-1:0] vertex_red,
	input  logic [COLOR_BITS-1:0] vertex_green,
	input  logic [COLOR_BITS-1:0] vertex_blue,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  pixel_valid,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0] pixel_red,
	output logic [COLOR_BITS-1:0] pixel_green,
	output logic [COLOR_BITS-1:0] pixel_blue,
	output logic                  last_pixel,
	output logic                  triangle_done
);

	function automatic logic [COLOR_BITS-1:0] to_color(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-FRAC_BITS-1:0] r;
		r = v[ACC_W-1:FRAC_BITS];
		if (v < 0)
			return '0;
		else if (r > {{(ACC_W-FRAC_BITS-COLOR_BITS){1'b0}}, {COLOR_BITS{1'b1}}})
			return '1;
		else
			return r[COLOR_BITS-1:0];
	endfunction

	logic [COORD_BITS-1:0]  vx_q [3];
	logic [COORD_BITS-1:0]  vy_q [3];
	logic [COLOR_BITS-1:0]  vc_q [3][3];
	logic signed [XW:0]     sx_q [3];
	logic signed [CW:0]     sc_q [3][3];
	logic [XW-1:0]          lx_q, rx_q;
	logic [CW-1:0]          lc_q [3];
	logic [CW-1:0]          rc_q [3];
	logic signed [CW:0]     stc_q [3];
	logic [COORD_BITS:0]    cx_q;
	logic signed [ACC_W-1:0] cc_q [3];
	logic [COORD_BITS-1:0]  row_q;
	phase_t                 phase_q;
	logic                   round_up_q;
	logic                   div_neg_q;

	logic                   p_valid_q;
	logic [COORD_BITS-1:0]  p_x_q, p_y_q;
	logic [COLOR_BITS-1:0]  p_c_q [3];

	logic                   o_valid_q;
	logic                   o_pix_q, o_last_q, o_done_q;
	logic [COORD_BITS-1:0]  o_x_q, o_y_q;
	logic [COLOR_BITS-1:0]  o_c_q [3];

	logic [1:0]             e_from, e_to, cidx, kidx, sh, le, re;
	logic [COLOR_BITS-1:0]  ca, cb;
	logic [COORD_BITS-1:0]  ea, eb, emag, dy;
	logic                   eneg, sneg, dy_pos;
	logic [CW-1:0]          smag;
	logic [NUM_W-1:0]       div_num, quo;
	logic [XW-1:0]          div_den;
	logic                   div_busy, div_done;
	logic signed [XW:0]     edge_val;
	logic signed [CW:0]     span_val;
	logic                   mid_hit;
	phase_t                 phase_seek;
	logic [XW:0]            lx_up;

	// edge 0: top to middle, edge 1: top to bottom, edge 2: middle to bottom
	assign e_from = (cmd.edge_sel == EDGE_LAST) ? 2'd1 : 2'd0;
	assign e_to   = (cmd.edge_sel == 2'd0) ? 2'd1 : 2'd2;
	assign cidx   = (cmd.comp_sel == COMP_X) ? 2'd0 : cmd.comp_sel - 2'd1;
	assign kidx   = (cmd.comp_sel == COMP_LAST) ? 2'd0 : cmd.comp_sel;

	assign ca     = vc_q[e_to][cidx];
	assign cb     = vc_q[e_from][cidx];
	assign ea     = (cmd.comp_sel == COMP_X) ? vx_q[e_to] : {{(COORD_BITS-COLOR_BITS){1'b0}}, ca};
	assign eb     = (cmd.comp_sel == COMP_X) ? vx_q[e_from] : {{(COORD_BITS-COLOR_BITS){1'b0}}, cb};
	assign eneg   = ea < eb;
	assign emag   = eneg ? eb - ea : ea - eb;
	assign dy_pos = vy_q[e_to] > vy_q[e_from];
	assign dy     = vy_q[e_to] - vy_q[e_from];

	assign sneg   = rc_q[kidx] < lc_q[kidx];
	assign smag   = sneg ? lc_q[kidx] - rc_q[kidx] : rc_q[kidx] - lc_q[kidx];

	assign div_num = cmd.span_mode ? {smag, {FRAC_BITS{1'b0}}}
	                               : {{(NUM_W-XW){1'b0}}, emag, {FRAC_BITS{1'b0}}};
	assign div_den = cmd.span_mode ? rx_q - lx_q : {{(XW-COORD_BITS){1'b0}}, dy};

	gtr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.busy   (div_busy),
		.done   (div_done)
	);

	always_comb begin
		if (!dy_pos)
			edge_val = '0;
		else if (div_neg_q)
			edge_val = -$signed(quo[XW:0]);
		else
			edge_val = $signed(quo[XW:0]);
	end

	// saturate the span step to one bit more than the colour
	always_comb begin
		if (!div_neg_q) begin
			if (quo > NUM_W'({CW{1'b1}}))
				span_val = {1'b0, {CW{1'b1}}};
			else
				span_val = $signed(quo[CW:0]);
		end else begin
			if (quo >= NUM_W'({1'b1, {CW{1'b0}}}))
				span_val = {1'b1, {CW{1'b0}}};
			else
				span_val = -$signed(quo[CW:0]);
		end
	end

	assign sh = (phase_q == PH_UPPER) ? 2'd0 : 2'd2;
	assign le = round_up_q ? sh : 2'd1;
	assign re = round_up_q ? 2'd1 : sh;

	always_comb begin
		phase_seek = phase_q;
		mid_hit    = 1'b0;
		if (phase_q == PH_UPPER && row_q >= vy_q[1]) begin
			mid_hit    = 1'b1;
			phase_seek = PH_LOWER;
		end
		if (phase_seek == PH_LOWER && row_q >= vy_q[2])
			phase_seek = PH_DONE;
	end

	assign lx_up = {1'b0, lx_q} + {{(COORD_BITS+1){1'b0}}, {FRAC_BITS{1'b1}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 3; s++) begin
				vx_q[s] <= '0;
				vy_q[s] <= '0;
				for (int k = 0; k < 3; k++)
					vc_q[s][k] <= '0;
			end
			phase_q    <= PH_DONE;
			round_up_q <= 1'b0;
			o_valid_q  <= 1'b0;
		end else begin
			if (cmd.load_vtx && vertex_slot != 2'd3) begin
				vx_q[vertex_slot]    <= vertex_x;
				vy_q[vertex_slot]    <= vertex_y;
				vc_q[vertex_slot][0] <= vertex_red;
				vc_q[vertex_slot][1] <= vertex_green;
				vc_q[vertex_slot][2] <= vertex_blue;
			end
			if (cmd.init_walk) begin
				round_up_q <= sx_q[0] < sx_q[1];
				phase_q    <= PH_UPPER;
			end else if (cmd.seek_a) begin
				phase_q <= phase_seek;
			end
			if (cmd.out_load)
				o_valid_q <= 1'b1;
			else if (out_ready)
				o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			div_neg_q <= cmd.span_mode ? sneg : eneg;
		if (cmd.edge_wr) begin
			if (cmd.comp_sel == COMP_X)
				sx_q[cmd.edge_sel] <= edge_val;
			else
				sc_q[cmd.edge_sel][cidx] <= edge_val[CW:0];
		end
		if (cmd.span_wr)
			stc_q[kidx] <= span_val;

		if (cmd.init_walk) begin
			lx_q  <= {vx_q[0], {FRAC_BITS{1'b0}}};
			rx_q  <= {vx_q[0], {FRAC_BITS{1'b0}}};
			row_q <= vy_q[0];
			for (int k = 0; k < 3; k++) begin
				lc_q[k] <= {vc_q[0][k], {FRAC_BITS{1'b0}}};
				rc_q[k] <= {vc_q[0][k], {FRAC_BITS{1'b0}}};
			end
		end else if (cmd.seek_a) begin
			// snap one walker onto the middle vertex
			if (mid_hit) begin
				if (round_up_q) begin
					lx_q <= {vx_q[1], {FRAC_BITS{1'b0}}};
					for (int k = 0; k < 3; k++)
						lc_q[k] <= {vc_q[1][k], {FRAC_BITS{1'b0}}};
				end else begin
					rx_q <= {vx_q[1], {FRAC_BITS{1'b0}}};
					for (int k = 0; k < 3; k++)
						rc_q[k] <= {vc_q[1][k], {FRAC_BITS{1'b0}}};
				end
			end
		end else if (cmd.walk) begin
			lx_q  <= lx_q + sx_q[le][XW-1:0];
			rx_q  <= rx_q + sx_q[re][XW-1:0];
			row_q <= row_q + 1'b1;
			for (int k = 0; k < 3; k++) begin
				lc_q[k] <= lc_q[k] + sc_q[le][k][CW-1:0];
				rc_q[k] <= rc_q[k] + sc_q[re][k][CW-1:0];
			end
		end

		if (cmd.span_init) begin
			cx_q <= round_up_q ? lx_up[XW:FRAC_BITS] : {1'b0, lx_q[XW-1:FRAC_BITS]};
			for (int k = 0; k < 3; k++)
				cc_q[k] <= {{(ACC_W-CW){1'b0}}, lc_q[k]};
		end else if (cmd.pix_capture) begin
			cx_q <= cx_q + 1'b1;
			for (int k = 0; k < 3; k++)
				cc_q[k] <= cc_q[k] + {{(ACC_W-CW-1){stc_q[k][CW]}}, stc_q[k]};
		end

		if (cmd.pix_capture) begin
			p_valid_q <= 1'b1;
			p_x_q     <= cx_q[COORD_BITS-1:0];
			p_y_q     <= row_q;
			for (int k = 0; k < 3; k++)
				p_c_q[k] <= to_color(cc_q[k]);
		end else if (cmd.pix_clear) begin
			p_valid_q <= 1'b0;
			p_x_q     <= '0;
			p_y_q     <= '0;
			for (int k = 0; k < 3; k++)
				p_c_q[k] <= '0;
		end

		if (cmd.out_load) begin
			o_pix_q  <= p_valid_q;
			o_x_q    <= p_x_q;
			o_y_q    <= p_y_q;
			o_last_q <= p_valid_q && phase_q == PH_DONE;
			o_done_q <= phase_q == PH_DONE;
			for (int k = 0; k < 3; k++)
				o_c_q[k] <= p_c_q[k];
		end
	end

	assign sts.div_busy      = div_busy;
	assign sts.div_done      = div_done;
	assign sts.dy_pos        = dy_pos;
	assign sts.phase_done    = phase_q == PH_DONE;
	assign sts.span_nonempty = rx_q > lx_q;
	assign sts.row_end       = {cx_q, {FRAC_BITS{1'b0}}} >= {1'b0, rx_q};
	assign sts.out_free      = !o_valid_q || out_ready;

	assign out_valid     = o_valid_q;
	assign pixel_valid   = o_pix_q;
	assign pixel_x       = o_x_q;
	assign pixel_y       = o_y_q;
	assign pixel_red     = o_c_q[0];
	assign pixel_green   = o_c_q[1];
	assign pixel_blue    = o_c_q[2];
	assign last_pixel    = o_last_q;
	assign triangle_done = o_done_q;

endmodule

// File: sv/gtr_ctrl.sv
// Sequencer for vertex loads, edge and span divisions, row seeking and pixel steps.
module gtr_ctrl import gtr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic opcode,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [1:0] edge_q, edge_d;
	logic [1:0] comp_q, comp_d;
	logic       accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edge_q  <= '0;
			comp_q  <= '0;
		end else begin
			state_q <= state_d;
			edge_q  <= edge_d;
			comp_q  <= comp_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		edge_d       = edge_q;
		comp_d       = comp_q;
		cmd          = '0;
		cmd.edge_sel = edge_q;
		cmd.comp_sel = comp_q;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					if (opcode == OP_LOAD) begin
						cmd.load_vtx  = 1'b1;
						cmd.pix_clear = 1'b1;
						edge_d        = '0;
						comp_d        = COMP_X;
						state_d       = ST_EDGE;
					end else if (sts.phase_done) begin
						cmd.pix_clear = 1'b1;
						state_d       = ST_FINISH;
					end else begin
						cmd.pix_capture = 1'b1;
						state_d         = ST_STEP;
					end
				end
			end
			ST_EDGE, ST_EDGE_WAIT: begin
				if (state_q == ST_EDGE && sts.dy_pos) begin
					cmd.div_start = 1'b1;
					state_d       = ST_EDGE_WAIT;
				end else if (state_q == ST_EDGE || sts.div_done) begin
					cmd.edge_wr = 1'b1;
					if (comp_q != COMP_LAST) begin
						comp_d  = comp_q + 2'd1;
						state_d = ST_EDGE;
					end else if (edge_q != EDGE_LAST) begin
						edge_d  = edge_q + 2'd1;
						comp_d  = COMP_X;
						state_d = ST_EDGE;
					end else begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.init_walk = 1'b1;
				state_d       = ST_SEEK_A;
			end
			ST_SEEK_A: begin
				cmd.seek_a = 1'b1;
				state_d    = ST_SEEK_B;
			end
			ST_SEEK_B: begin
				if (sts.phase_done) begin
					state_d = ST_FINISH;
				end else if (sts.span_nonempty) begin
					comp_d  = '0;
					state_d = ST_SPAN;
				end else begin
					// empty row: step the edges and look again
					cmd.walk = 1'b1;
					state_d  = ST_SEEK_A;
				end
			end
			ST_SPAN: begin
				cmd.span_mode = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_SPAN_WAIT;
			end
			ST_SPAN_WAIT: begin
				cmd.span_mode = 1'b1;
				if (sts.div_done) begin
					cmd.span_wr = 1'b1;
					if (comp_q == SPAN_LAST) begin
						state_d = ST_SPAN_INIT;
					end else begin
						comp_d  = comp_q + 2'd1;
						state_d = ST_SPAN;
					end
				end
			end
			ST_SPAN_INIT: begin
				cmd.span_init = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_STEP: begin
				if (sts.row_end) begin
					cmd.walk = 1'b1;
					state_d  = ST_SEEK_A;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy) else $error("divider restarted while busy");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("result word overwritten");

	a_accept_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE) else $error("accepted word not processed");

	a_wait_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPAN_WAIT && !sts.div_busy && !sts.div_done) |-> 1'b0)
		else $error("span wait with idle divider");

endmodule

// File: sv/gouraud_triangle_rasterizer.sv
// Gouraud triangle rasteriser: load three vertices, then step out shaded pixels.
//
// Input channel (in_valid/in_ready): opcode 0 loads vertex_slot with position and
// colour and restarts the walk; opcode 1 asks for the next pixel. Vertices must be
// loaded top, middle, bottom in ascending row order. Each accepted word yields exactly
// one result word on the output channel (out_valid/out_ready).
// A pixel inside a span is captured on acceptance, then passes the step and finish
// states before out_valid is registered. When a step closes a row, the next row start
// costs three span colour divisions on the shared radix-2 divider, plus a pass through
// the seek states per skipped empty row. A load divides all non-flat edge components before
// the first row is sought. One word is worked on at a time; in_ready is high only while
// the sequencer is idle, so a pixel request is taken only once the last word's result is loaded.
// A finished result sits in the output register while the next word is accepted; if
// the receiver stalls, the sequencer holds at the end of that word until it is taken.
// After reset the vertex store is zero and no triangle is loaded: requests return
// triangle_done with no pixel.
module gouraud_triangle_rasterizer import gtr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [1:0]            vertex_slot,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic [COLOR_BITS-1:0] vertex_red,
	input  logic [COLOR_BITS-1:0] vertex_green,
	input  logic [COLOR_BITS-1:0] vertex_blue,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  pixel_valid,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0] pixel_red,
	output logic [COLOR_BITS-1:0] pixel_green,
	output logic [COLOR_BITS-1:0] pixel_blue,
	output logic                  last_pixel,
	output logic                  triangle_done
);

	cmd_t cmd;
	sts_t sts;

	gtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	gtr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.vertex_slot   (vertex_slot),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.vertex_red    (vertex_red),
		.vertex_green  (vertex_green),
		.vertex_blue   (vertex_blue),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.pixel_valid   (pixel_valid),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_red     (pixel_red),
		.pixel_green   (pixel_green),
		.pixel_blue    (pixel_blue),
		.last_pixel    (last_pixel),
		.triangle_done (triangle_done)
	);

endmodule
